@@ src/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the point rotation pipeline
// Widths of the coordinate path, the CORDIC arctangent table and the
// data word that travels along the chain of CORDIC cells.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int PRC_STAGES = 24;
  localparam int IDX_W      = $clog2(PRC_STAGES);

  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 31;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int CV_W     = 34;
  // Cosine and sine span [-2^30, 2^30], so the positive end needs a 32-bit word.
  localparam int TRIG_W   = 32;
  localparam int PROD_W   = TRIG_W + DIFF_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int SUM_W    = ACC_W - 30 + 1;

  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 64;

  localparam logic signed [ANGLE_W-1:0] PI_Q28      = 31'sd843314857;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q28 = 31'sd421657428;
  localparam logic signed [CV_W-1:0]    GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CV_W-1:0]    ONE_Q30     = 34'sd1073741824;
  localparam logic signed [ACC_W-1:0]   ROUND_HALF  = ACC_W'(65'sd536870912);
  localparam logic signed [SUM_W-1:0]   COORD_MAX   = SUM_W'(36'sd2147483647);
  localparam logic signed [SUM_W-1:0]   COORD_MIN   = SUM_W'(-36'sd2147483648);

  // Data carried by every CORDIC cell alongside the rotation vector.
  typedef struct packed {
    logic signed [CV_W-1:0]    x;
    logic signed [CV_W-1:0]    y;
    logic signed [CV_W-1:0]    z;
    logic                      flip;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cell_data_t;

  // atan(2^-i) in Q2.30, truncated toward zero.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd66890614;
      5'd5:  v = 30'd33502555;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/point_rotate_about_center.sv @@
// ----------------------------------------------------------------------------
// point_rotate_about_center: rotate a point about a centre by an angle
// Fold stage, a chain of CORDIC cells for sine and cosine, then the
// products, rounding and saturation of the rotated coordinates.
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields (low bit first)
//  s        in         point_x, point_y, center_x, center_y, angle, pad
//  m        out        rotated_x, rotated_y
//
// One item is accepted every cycle while the pipeline is not held. The
// stages are 24 CORDIC cells, the fold stage and four post stages, the
// last of which is the output register. The whole pipeline advances
// together: it holds while the output register is full and not taken.
// Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module point_rotate_about_center (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // point_x[31:0], point_y[63:32], center_x[95:64], center_y[127:96],
  // angle[158:128], zero[159]
  input  logic [prc_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // rotated_x[31:0], rotated_y[63:32]
  output logic [prc_pkg::M_TDATA_W-1:0] m_tdata
);
  import prc_pkg::*;

  logic       en;
  logic       chain_valid [PRC_STAGES+1];
  cell_data_t chain_data  [PRC_STAGES+1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  prc_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < PRC_STAGES; i++) begin : g_cell
    prc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (IDX_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  prc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[PRC_STAGES]),
    .in_data   (chain_data[PRC_STAGES]),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

@@ src/prc_fold.sv @@
// ----------------------------------------------------------------------------
// prc_fold: angle clamp, quadrant fold and centre offset
// Registers the start vector of the CORDIC chain for one accepted item.
// ----------------------------------------------------------------------------
module prc_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [prc_pkg::S_TDATA_W-1:0] in_data,
  output logic                          out_valid,
  output prc_pkg::cell_data_t           out_data
);
  import prc_pkg::*;

  logic signed [COORD_W-1:0] px, py, cx, cy;
  logic signed [ANGLE_W-1:0] ang_in, ang_c;
  logic signed [ANGLE_W:0]   ang_f;
  logic                      flip;
  cell_data_t                d_next;

  always_comb begin
    px     = in_data[31:0];
    py     = in_data[63:32];
    cx     = in_data[95:64];
    cy     = in_data[127:96];
    ang_in = in_data[158:128];

    if (ang_in > PI_Q28) begin
      ang_c = PI_Q28;
    end else if (ang_in < -PI_Q28) begin
      ang_c = -PI_Q28;
    end else begin
      ang_c = ang_in;
    end

    // Fold into [-pi/2, pi/2]; the sign of the result is restored later.
    if (ang_c > HALF_PI_Q28) begin
      ang_f = (ANGLE_W+1)'(ang_c) - (ANGLE_W+1)'(PI_Q28);
      flip  = 1'b1;
    end else if (ang_c < -HALF_PI_Q28) begin
      ang_f = (ANGLE_W+1)'(ang_c) + (ANGLE_W+1)'(PI_Q28);
      flip  = 1'b1;
    end else begin
      ang_f = (ANGLE_W+1)'(ang_c);
      flip  = 1'b0;
    end

    d_next.x    = GAIN_Q30;
    d_next.y    = '0;
    d_next.z    = CV_W'({ang_f, 2'b00});
    d_next.flip = flip;
    d_next.dx   = DIFF_W'(px) - DIFF_W'(cx);
    d_next.dy   = DIFF_W'(py) - DIFF_W'(cy);
    d_next.cx   = cx;
    d_next.cy   = cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d_next;
    end
  end

endmodule

@@ src/prc_cell.sv @@
// ----------------------------------------------------------------------------
// prc_cell: one CORDIC rotation cell
// Rotates the vector by +-atan(2^-idx) and passes the item to the next cell.
// ----------------------------------------------------------------------------
module prc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [prc_pkg::IDX_W-1:0] idx,
  input  logic                      in_valid,
  input  prc_pkg::cell_data_t       in_data,
  output logic                      out_valid,
  output prc_pkg::cell_data_t       out_data
);
  import prc_pkg::*;

  logic signed [CV_W-1:0] xs, ys, step;
  cell_data_t             d_next;

  always_comb begin
    xs     = in_data.x >>> idx;
    ys     = in_data.y >>> idx;
    step   = CV_W'(atan_q30(5'(idx)));
    d_next = in_data;
    if (!in_data.z[CV_W-1]) begin
      d_next.x = in_data.x - ys;
      d_next.y = in_data.y + xs;
      d_next.z = in_data.z - step;
    end else begin
      d_next.x = in_data.x + ys;
      d_next.y = in_data.y - xs;
      d_next.z = in_data.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d_next;
    end
  end

endmodule

@@ src/prc_post.sv @@
// ----------------------------------------------------------------------------
// prc_post: trig clamp, products, rounding and saturation
// Four registered steps from the CORDIC result to the output register.
// ----------------------------------------------------------------------------
module prc_post (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  prc_pkg::cell_data_t           in_data,
  output logic                          out_valid,
  output logic [prc_pkg::M_TDATA_W-1:0] out_data
);
  import prc_pkg::*;

  // Step 1: clamped and sign-restored cosine and sine.
  logic                      v1;
  logic signed [TRIG_W-1:0]  c1, s1, ns1;
  logic signed [DIFF_W-1:0]  dx1, dy1;
  logic signed [COORD_W-1:0] cx1, cy1;
  // Step 2: products.
  logic                      v2;
  logic signed [PROD_W-1:0]  pa2, pb2, qa2, qb2;
  logic signed [COORD_W-1:0] cx2, cy2;
  // Step 3: rounded sums.
  logic                      v3;
  logic signed [ACC_W-1:0]   ax3, ay3;
  logic signed [COORD_W-1:0] cx3, cy3;

  logic signed [CV_W-1:0]    c_cl, s_cl;
  logic signed [TRIG_W-1:0]  c_next, s_next;
  logic signed [SUM_W-1:0]   rx_sum, ry_sum;
  logic signed [COORD_W-1:0] rx_next, ry_next;

  always_comb begin
    if (in_data.x > ONE_Q30) begin
      c_cl = ONE_Q30;
    end else if (in_data.x < -ONE_Q30) begin
      c_cl = -ONE_Q30;
    end else begin
      c_cl = in_data.x;
    end
    if (in_data.y > ONE_Q30) begin
      s_cl = ONE_Q30;
    end else if (in_data.y < -ONE_Q30) begin
      s_cl = -ONE_Q30;
    end else begin
      s_cl = in_data.y;
    end
    if (in_data.flip) begin
      c_next = -TRIG_W'(c_cl);
      s_next = -TRIG_W'(s_cl);
    end else begin
      c_next = TRIG_W'(c_cl);
      s_next = TRIG_W'(s_cl);
    end
  end

  always_comb begin
    rx_sum = SUM_W'(ax3 >>> 30) + SUM_W'(cx3);
    ry_sum = SUM_W'(ay3 >>> 30) + SUM_W'(cy3);
    if (rx_sum > COORD_MAX) begin
      rx_next = COORD_W'(COORD_MAX);
    end else if (rx_sum < COORD_MIN) begin
      rx_next = COORD_W'(COORD_MIN);
    end else begin
      rx_next = COORD_W'(rx_sum);
    end
    if (ry_sum > COORD_MAX) begin
      ry_next = COORD_W'(COORD_MAX);
    end else if (ry_sum < COORD_MIN) begin
      ry_next = COORD_W'(COORD_MIN);
    end else begin
      ry_next = COORD_W'(ry_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= c_next;
      s1  <= s_next;
      ns1 <= -s_next;
      dx1 <= in_data.dx;
      dy1 <= in_data.dy;
      cx1 <= in_data.cx;
      cy1 <= in_data.cy;

      pa2 <= PROD_W'(c1) * PROD_W'(dx1);
      pb2 <= PROD_W'(ns1) * PROD_W'(dy1);
      qa2 <= PROD_W'(s1) * PROD_W'(dx1);
      qb2 <= PROD_W'(c1) * PROD_W'(dy1);
      cx2 <= cx1;
      cy2 <= cy1;

      ax3 <= ACC_W'(pa2) + ACC_W'(pb2) + ROUND_HALF;
      ay3 <= ACC_W'(qa2) + ACC_W'(qb2) + ROUND_HALF;
      cx3 <= cx2;
      cy3 <= cy2;

      out_data <= {ry_next, rx_next};
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for point_rotate_about_center
// Streams points, centres and angles into the block with random gaps and
// random output stalls. A bit-accurate CORDIC rotation in the bench works
// out each rotated point, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint ANG_PI        = 843314857;
  localparam longint ANG_HALF_PI   = 421657428;
  localparam longint CORDIC_GAIN   = 652032874;
  localparam longint UNIT_Q30      = longint'(1) << 30;
  localparam int     CORDIC_STAGES = 24;
  localparam int     RANDOM_ITEMS  = 1150;
  localparam int     IDLE_LIMIT    = 4000;
  localparam int     TAIL_CYCLES   = 40;
  localparam int     PRINT_LIMIT   = 100;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [30:0] ang;
    bit                 drain;
    bit                 no_gap;
  } pt_item_t;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
  } rot_point_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [prc_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [prc_pkg::M_TDATA_W-1:0] m_tdata;

  pt_item_t   point_q[$];
  rot_point_t rotated_q[$];
  int         fail_count  = 0;
  int         idle_cycles = 0;
  int         send_gap    = 0;
  bit         gap_drawn   = 1'b0;
  int         stall_left  = 0;
  bit         rx_burst    = 1'b0;

  // atan(2^-i) in Q2.30, truncated toward zero.
  longint arctan_q30 [32] = '{
    843314856, 497837829, 263043836, 133525158,
    66890614, 33502555, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127,
    63, 31, 15, 7,
    3, 1, 0, 0
  };

  point_rotate_about_center u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rounds a Q2.30 by Q16.16 sum of products back to Q16.16, adds the
  // centre coordinate and saturates to the 32-bit range.
  function automatic logic [31:0] round_sat(longint prod_sum, logic signed [31:0] base);
    longint v;
    v = ((prod_sum + (longint'(1) << 29)) >>> 30) + longint'(base);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    else if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic rot_point_t rotate_about(pt_item_t it);
    longint     ang;
    longint     x;
    longint     y;
    longint     z;
    longint     xs;
    longint     ys;
    longint     c;
    longint     s;
    longint     dx;
    longint     dy;
    bit         flip;
    int         i;
    rot_point_t r;
    ang  = longint'(it.ang);
    flip = 1'b0;
    if (ang > ANG_PI) ang = ANG_PI;
    else if (ang < -ANG_PI) ang = -ANG_PI;
    // Fold into [-pi/2, pi/2]; a half turn is undone by negating sin and cos.
    if (ang > ANG_HALF_PI) begin
      ang  = ang - ANG_PI;
      flip = 1'b1;
    end else if (ang < -ANG_HALF_PI) begin
      ang  = ang + ANG_PI;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = ang * 4;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q30[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q30[i];
      end
    end
    c = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
    s = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
    if (flip) begin
      c = -c;
      s = -s;
    end
    dx   = longint'(it.px) - longint'(it.cx);
    dy   = longint'(it.py) - longint'(it.cy);
    r.rx = round_sat(c * dx - s * dy, it.cx);
    r.ry = round_sat(s * dx + c * dy, it.cy);
    return r;
  endfunction

  task automatic add_item(logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] cx, logic signed [31:0] cy,
                          logic signed [30:0] ang, bit drain, bit no_gap);
    pt_item_t it;
    it.px     = px;
    it.py     = py;
    it.cx     = cx;
    it.cy     = cy;
    it.ang    = ang;
    it.drain  = drain;
    it.no_gap = no_gap;
    point_q.push_back(it);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2, 3:    return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      4:       return 32'h7fffffff - $urandom_range(0, 65536);
      default: return 32'h80000000 + $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic signed [30:0] rand_angle();
    longint edge_ang;
    case ($urandom_range(0, 7))
      6: return 31'($urandom);
      7: begin
        case ($urandom_range(0, 3))
          0:       edge_ang = ANG_PI;
          1:       edge_ang = -ANG_PI;
          2:       edge_ang = ANG_HALF_PI;
          default: edge_ang = -ANG_HALF_PI;
        endcase
        return 31'(edge_ang + longint'($urandom_range(0, 8)) - 4);
      end
      default: return 31'(longint'($urandom_range(0, 32'd1686629714)) - ANG_PI);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    // Keep the log readable when everything goes wrong; every failure counts.
    if (fail_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // Sender: one item is offered at a time, after a gap drawn for that item.
  always @(posedge clk) begin : sender
    logic held;
    logic launch;
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      send_gap  = 0;
      gap_drawn = 1'b0;
    end else begin
      held   = s_tvalid;
      launch = 1'b0;
      if (s_tvalid && s_tready) begin
        rotated_q.push_back(rotate_about(point_q.pop_front()));
        held      = 1'b0;
        gap_drawn = 1'b0;
      end
      if (!held && point_q.size() > 0) begin
        if (!gap_drawn) begin
          send_gap  = point_q[0].no_gap ? 0 : $urandom_range(0, 16);
          gap_drawn = 1'b1;
        end
        if (!(point_q[0].drain && rotated_q.size() != 0)) begin
          if (send_gap > 0) send_gap--;
          else launch = 1'b1;
        end
      end
      s_tvalid <= held | launch;
      if (launch) begin
        s_tdata <= {1'b0, point_q[0].ang, point_q[0].cy, point_q[0].cx,
                    point_q[0].py, point_q[0].px};
      end
    end
  end

  // Receiver: checks each item in order, then stalls for a drawn number of cycles.
  always @(posedge clk) begin : receiver
    rot_point_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rotated_q.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing expected", m_tdata));
        end else begin
          want = rotated_q.pop_front();
          if (m_tdata[31:0] !== want.rx || m_tdata[63:32] !== want.ry)
            report_mismatch($sformatf("rotated_x %h (want %h) rotated_y %h (want %h)",
                                      m_tdata[31:0], want.rx, m_tdata[63:32], want.ry));
        end
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k;
    bit burst;
    // Identity, quarter and half turns, and the fold boundaries.
    add_item(0, 0, 0, 0, 0, 1'b0, 1'b0);
    add_item(32'h00010000, 0, 0, 0, 31'(ANG_HALF_PI), 1'b0, 1'b0);
    add_item(32'h00010000, 0, 0, 0, 31'(ANG_PI), 1'b0, 1'b0);
    add_item(32'h00010000, 0, 0, 0, 31'(-ANG_PI), 1'b0, 1'b0);
    add_item(32'h00010000, 0, 0, 0, 31'(-ANG_HALF_PI), 1'b0, 1'b0);
    add_item(32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000,
             31'(ANG_HALF_PI + 1), 1'b0, 1'b1);
    add_item(32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000,
             31'(-ANG_HALF_PI - 1), 1'b0, 1'b1);
    // Angles beyond pi are clamped.
    add_item(32'h00050000, 32'hfffd0000, 32'h00010000, 0, 31'h3fffffff, 1'b0, 1'b0);
    add_item(32'h00050000, 32'hfffd0000, 32'h00010000, 0, 31'h40000000, 1'b0, 1'b0);
    add_item(32'h00050000, 32'hfffd0000, 0, 32'h00010000, 31'(ANG_PI + 1), 1'b0, 1'b0);
    add_item(32'h00050000, 32'hfffd0000, 0, 32'h00010000, 31'(-ANG_PI - 1), 1'b0, 1'b0);
    // Coordinate overflow in both directions.
    add_item(32'h7fffffff, 32'h7fffffff, 0, 0, 31'd210828714, 1'b0, 1'b0);
    add_item(32'h80000000, 32'h80000000, 0, 0, 31'd210828714, 1'b0, 1'b0);
    add_item(32'h7fffffff, 0, 32'h80000000, 0, 31'(ANG_PI), 1'b0, 1'b0);
    add_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 1'b0, 1'b1);
    add_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
             1'b0, 1'b0);
    add_item(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa,
             1'b0, 1'b0);
    add_item(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 31'h55555555,
             1'b0, 1'b0);
    add_item(32'h00640000, 0, 0, 0, 31'd1, 1'b0, 1'b1);
    add_item(32'h00640000, 0, 0, 0, 31'h7fffffff, 1'b0, 1'b1);

    burst = 1'b0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      // The sender holds back at two points until the pipeline has drained.
      add_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_angle(),
               (k == 0) || (k == RANDOM_ITEMS / 2), burst);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (point_q.size() != 0 || rotated_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
